// ===== sv/pqe_pkg.sv =====
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared constants, codes, pipeline context type and saturating helpers for
// the piecewise quartic evaluator.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int SEGMENTS  = 4;
  localparam int DEGREE    = 4;
  localparam int FRAC_BITS = 40;
  localparam int WORD_W    = 64;
  localparam int SEG_W     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int NUM_REGS  = 8;

  // multiplier unit depth, total pipeline depth from accept to strobe
  localparam int MUL_STAGES = 5;
  localparam int LATENCY    = 2 + (DEGREE + 2) * MUL_STAGES;

  // action codes
  localparam logic [1:0] ACT_EVAL  = 2'd0;
  localparam logic [1:0] ACT_COEF  = 2'd1;
  localparam logic [1:0] ACT_BREAK = 2'd2;

  // status codes
  localparam logic [1:0] ST_EVAL  = 2'd0;
  localparam logic [1:0] ST_OOR   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FWD_IN_OFFSET  = 3'd0;
  localparam logic [2:0] REG_FWD_IN_GAIN    = 3'd1;
  localparam logic [2:0] REG_FWD_OUT_GAIN   = 3'd2;
  localparam logic [2:0] REG_FWD_OUT_OFFSET = 3'd3;
  localparam logic [2:0] REG_REV_IN_OFFSET  = 3'd4;
  localparam logic [2:0] REG_REV_IN_GAIN    = 3'd5;
  localparam logic [2:0] REG_REV_OUT_GAIN   = 3'd6;
  localparam logic [2:0] REG_REV_OUT_OFFSET = 3'd7;

  localparam logic [WORD_W-1:0] FX_ONE   = WORD_W'(64'd1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FX_M_ONE = ~FX_ONE + WORD_W'(64'd1);
  localparam logic [WORD_W-1:0] S64_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] S64_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

  // context that travels with each item down the pipeline
  typedef struct packed {
    logic                          valid;
    logic                          dir;
    logic [1:0]                    status;
    logic [SEG_W-1:0]              seg;
    logic [WORD_W-1:0]             fixed;
    logic [WORD_W-1:0]             u;
    logic [DEGREE:0][WORD_W-1:0]   coef;
  } ctx_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
    return s[WORD_W-1:0];
  endfunction

  // context with its valid bit dropped while clr is high
  function automatic ctx_t ctx_gate(input ctx_t c, input logic clr);
    ctx_t g;
    g       = c;
    g.valid = c.valid & ~clr;
    return g;
  endfunction

endpackage

// ===== sv/pqe_ram.sv =====
// ----------------------------------------------------------------------------
// pqe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pqe_front.sv =====
// ----------------------------------------------------------------------------
// pqe_front
// Breakpoint store, coefficient RAMs, segment search and offset subtract.
// Two stages: search and RAM read, then coefficient capture and x - offset.
// ----------------------------------------------------------------------------
module pqe_front import pqe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic              direction,
  input  logic [2:0]        slot,
  input  logic [2:0]        term,
  input  logic [WORD_W-1:0] operand_value,
  input  logic [WORD_W-1:0] in_offset_fwd,
  input  logic [WORD_W-1:0] in_offset_rev,
  output ctx_t              ctx_out,
  output logic [WORD_W-1:0] diff_out
);

  localparam int RAM_DEPTH = 2 * SEGMENTS;

  logic [WORD_W-1:0] bp [2][SEGMENTS+1];
  logic [SEGMENTS:0] below;
  logic              hit;
  logic [SEG_W-1:0]  seg_sel;
  logic              wr_coef;
  logic              wr_bp;
  ctx_t              ctx_new;
  ctx_t              ctx0;
  ctx_t              ctx_cap;
  logic [WORD_W-1:0] x0;
  logic [DEGREE:0][WORD_W-1:0] q;

  // write qualification
  always_comb begin
    wr_coef = accept && (action == ACT_COEF) && (int'(slot) < SEGMENTS)
              && (int'(term) <= DEGREE);
    wr_bp   = accept && (action == ACT_BREAK) && (int'(slot) <= SEGMENTS);
  end

  // breakpoint store
  always_ff @(posedge clk) begin
    for (int i = 0; i <= SEGMENTS; i++) begin
      if (wr_bp && (int'(slot) == i)) begin
        bp[direction][i] <= operand_value;
      end
    end
  end

  // segment search: first upper breakpoint above x
  always_comb begin
    for (int i = 0; i <= SEGMENTS; i++) begin
      below[i] = $signed(operand_value) < $signed(bp[direction][i]);
    end
    hit     = 1'b0;
    seg_sel = '0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (below[i+1]) begin
        hit     = 1'b1;
        seg_sel = SEG_W'(i);
      end
    end
    if (below[0] || !below[SEGMENTS]) begin
      hit = 1'b0;
    end
  end

  // coefficient RAMs, one per power
  for (genvar t = 0; t <= DEGREE; t++) begin : g_coef
    pqe_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr_coef && (int'(term) == t)),
      .waddr ({direction, SEG_W'(slot)}),
      .wdata (operand_value),
      .raddr ({direction, seg_sel}),
      .rdata (q[t])
    );
  end

  // context for the new item
  always_comb begin
    ctx_new        = '0;
    ctx_new.valid  = accept;
    ctx_new.dir    = direction;
    ctx_new.status = ST_OOR;
    ctx_new.fixed  = '0;
    unique case (action)
      ACT_EVAL: begin
        ctx_new.fixed = FX_M_ONE;
        if (hit) begin
          ctx_new.status = ST_EVAL;
          ctx_new.seg    = seg_sel;
        end
      end
      ACT_COEF:  ctx_new.status = wr_coef ? ST_WRITE : ST_OOR;
      ACT_BREAK: ctx_new.status = wr_bp ? ST_WRITE : ST_OOR;
      default:   ctx_new.status = ST_OOR;
    endcase
  end

  // stage 0 context with the coefficients read for it
  always_comb begin
    ctx_cap      = ctx0;
    ctx_cap.coef = q;
  end

  // stage 0 and stage 1
  always_ff @(posedge clk) begin
    ctx0     <= ctx_gate(ctx_new, rst);
    x0       <= operand_value;
    ctx_out  <= ctx_gate(ctx_cap, rst);
    diff_out <= sat_sub(x0, ctx0.dir ? in_offset_rev : in_offset_fwd);
  end

endmodule

// ===== sv/pqe_mul.sv =====
// ----------------------------------------------------------------------------
// pqe_mul
// Five-stage saturating fixed-point multiply-add: sat(round(a*b)) + addend.
// Magnitudes, 32x32 partial products, 128-bit sum, sign/round/saturate, add.
// ----------------------------------------------------------------------------
module pqe_mul import pqe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] addend,
  input  ctx_t              ctx_in,
  output logic [WORD_W-1:0] p,
  output ctx_t              ctx_out
);

  localparam int HALF = WORD_W / 2;
  localparam int PW   = 2 * WORD_W;
  localparam logic [PW-1:0] ROUND = PW'(1) << (FRAC_BITS - 1);

  ctx_t ctx1, ctx2, ctx3, ctx4;
  logic [WORD_W-1:0] add1, add2, add3, add4;
  logic [WORD_W-1:0] ua, ub;
  logic              neg1, neg2, neg3;
  logic [WORD_W-1:0] p00, p01, p10, p11;
  logic [PW-1:0]     mag;
  logic [PW-1:0]     rnd;
  logic [WORD_W-1:0] prod_next;
  logic [WORD_W-1:0] prod;

  // sign, round and saturate
  always_comb begin
    rnd = (mag ^ {PW{neg3}}) + PW'(neg3) + ROUND;
    if (rnd[PW-1:FRAC_BITS+WORD_W-1] != {(PW-FRAC_BITS-WORD_W+1){rnd[FRAC_BITS+WORD_W-1]}})
    begin
      prod_next = rnd[PW-1] ? S64_MIN : S64_MAX;
    end else begin
      prod_next = rnd[FRAC_BITS +: WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    // magnitudes
    ua   <= a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
    ub   <= b[WORD_W-1] ? (~b + WORD_W'(1)) : b;
    neg1 <= a[WORD_W-1] ^ b[WORD_W-1];
    add1 <= addend;
    ctx1 <= ctx_gate(ctx_in, rst);
    // partial products
    p00  <= ua[HALF-1:0] * ub[HALF-1:0];
    p01  <= ua[HALF-1:0] * ub[WORD_W-1:HALF];
    p10  <= ua[WORD_W-1:HALF] * ub[HALF-1:0];
    p11  <= ua[WORD_W-1:HALF] * ub[WORD_W-1:HALF];
    neg2 <= neg1;
    add2 <= add1;
    ctx2 <= ctx_gate(ctx1, rst);
    // full magnitude
    mag  <= PW'(p00) + (PW'(p01) << HALF) + (PW'(p10) << HALF) + (PW'(p11) << WORD_W);
    neg3 <= neg2;
    add3 <= add2;
    ctx3 <= ctx_gate(ctx2, rst);
    // rounded product
    prod <= prod_next;
    add4 <= add3;
    ctx4 <= ctx_gate(ctx3, rst);
    // accumulate
    p       <= sat_add(prod, add4);
    ctx_out <= ctx_gate(ctx4, rst);
  end

endmodule

// ===== sv/piecewise_quartic_evaluator.sv =====
// ----------------------------------------------------------------------------
// piecewise_quartic_evaluator
// Two-direction four-segment quartic curve, Horner evaluated in a pipeline.
// ----------------------------------------------------------------------------
// Pipeline from accept to done: 2 front stages, then 6 multiply-adds of
// 5 stages each. Throughput: one transaction per cycle; busy is high only
// in reset. Reset clears pipeline valid bits and the offset/gain registers;
// coefficient and breakpoint stores hold nothing defined until written.
// Results cannot be stalled by the receiver.
module piecewise_quartic_evaluator import pqe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action,
  input  logic              direction,
  input  logic [2:0]        slot,
  input  logic [2:0]        term,
  input  logic [WORD_W-1:0] operand_value,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output logic              done,
  output logic [WORD_W-1:0] result_value,
  output logic [1:0]        status,
  output logic [1:0]        segment_used
);

  logic [WORD_W-1:0] regs [NUM_REGS];
  logic              accept;
  ctx_t              ctx_f;
  logic [WORD_W-1:0] diff_f;
  ctx_t              ctx_u;
  logic [WORD_W-1:0] u_val;
  ctx_t              ctx_h [DEGREE+1];
  logic [WORD_W-1:0] acc   [DEGREE+1];
  ctx_t              ctx_o;
  logic [WORD_W-1:0] out_val;

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_FWD_IN_OFFSET]  <= '0;
      regs[REG_FWD_IN_GAIN]    <= FX_ONE;
      regs[REG_FWD_OUT_GAIN]   <= FX_ONE;
      regs[REG_FWD_OUT_OFFSET] <= '0;
      regs[REG_REV_IN_OFFSET]  <= '0;
      regs[REG_REV_IN_GAIN]    <= FX_ONE;
      regs[REG_REV_OUT_GAIN]   <= FX_ONE;
      regs[REG_REV_OUT_OFFSET] <= '0;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // front: stores, search, x - in_offset
  pqe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .direction     (direction),
    .slot          (slot),
    .term          (term),
    .operand_value (operand_value),
    .in_offset_fwd (regs[REG_FWD_IN_OFFSET]),
    .in_offset_rev (regs[REG_REV_IN_OFFSET]),
    .ctx_out       (ctx_f),
    .diff_out      (diff_f)
  );

  // input scaling
  pqe_mul u_in_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (ctx_f.dir ? regs[REG_REV_IN_GAIN] : regs[REG_FWD_IN_GAIN]),
    .b       (diff_f),
    .addend  ('0),
    .ctx_in  (ctx_f),
    .p       (u_val),
    .ctx_out (ctx_u)
  );

  // Horner chain, highest power first
  always_comb begin
    ctx_h[0]   = ctx_u;
    ctx_h[0].u = u_val;
    acc[0]     = ctx_u.coef[DEGREE];
  end

  for (genvar j = 0; j < DEGREE; j++) begin : g_horner
    pqe_mul u_step (
      .clk     (clk),
      .rst     (rst),
      .a       (acc[j]),
      .b       (ctx_h[j].u),
      .addend  (ctx_h[j].coef[DEGREE-1-j]),
      .ctx_in  (ctx_h[j]),
      .p       (acc[j+1]),
      .ctx_out (ctx_h[j+1])
    );
  end

  // output scaling and offset
  pqe_mul u_out_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (ctx_h[DEGREE].dir ? regs[REG_REV_OUT_GAIN] : regs[REG_FWD_OUT_GAIN]),
    .b       (acc[DEGREE]),
    .addend  (ctx_h[DEGREE].dir ? regs[REG_REV_OUT_OFFSET] : regs[REG_FWD_OUT_OFFSET]),
    .ctx_in  (ctx_h[DEGREE]),
    .p       (out_val),
    .ctx_out (ctx_o)
  );

  // result ports
  assign done         = ctx_o.valid;
  assign status       = ctx_o.status;
  assign result_value = (ctx_o.status == ST_EVAL) ? out_val : ctx_o.fixed;
  assign segment_used = (ctx_o.status == ST_EVAL) ? 2'(ctx_o.seg) : 2'd0;

  // every accepted transaction returns exactly at the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing at pipeline latency");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_WRITE) |-> (result_value == '0 && segment_used == 2'd0))
    else $error("write transaction returned nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_EVAL || status == ST_OOR || status == ST_WRITE))
    else $error("bad status code");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(accept, LATENCY)) |-> $past(rst, LATENCY))
    else $error("result without accepted transaction");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise quartic evaluator. Loads curve
// tables for both directions, then runs directed boundary transactions and
// random phases under several offset/gain settings. A built-in predictor
// computes each response in order; a monitor checks every strobed result.
// ----------------------------------------------------------------------------
module tb import pqe_pkg::*; ();

  localparam logic [1:0] ACT_NONE   = 2'd3;   // unused action code
  localparam int         IDLE_LIMIT = 4000;
  localparam longint     FX_MAXV    = 64'sh7fff_ffff_ffff_ffff;
  localparam longint     FX_MINV    = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [1:0]  act;
    logic        dir;
    logic [2:0]  slot;
    logic [2:0]  term;
    logic [63:0] val;
  } curve_txn_t;

  typedef struct {
    logic [63:0] val;
    logic [1:0]  st;
    logic [1:0]  seg;
  } curve_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = '0;
  logic        direction = 1'b0;
  logic [2:0]  slot = '0;
  logic [2:0]  term = '0;
  logic [63:0] operand_value = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        done;
  logic [63:0] result_value;
  logic [1:0]  status;
  logic [1:0]  segment_used;

  piecewise_quartic_evaluator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .direction(direction), .slot(slot), .term(term),
    .operand_value(operand_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result_value(result_value), .status(status),
    .segment_used(segment_used)
  );

  always #2 clk = ~clk;

  // predictor state, updated in accept order
  longint coef_mem[2][SEGMENTS][DEGREE+1];
  longint bkpt_mem[2][SEGMENTS+1];
  longint scale_regs[NUM_REGS];

  // generator shadow, tracks what has been written so far in the stream
  longint gen_bkpt[2][SEGMENTS+1];
  bit     gen_bkpt_set[2][SEGMENTS+1];
  bit     gen_coef_set[2][SEGMENTS][DEGREE+1];

  curve_txn_t  pending_txns[$];
  curve_resp_t responses_due[$];
  curve_txn_t  cur_txn;
  curve_resp_t new_resp;
  curve_resp_t exp_resp;

  int n_err, n_eval, n_oor, n_write, n_rej, n_done;
  int burst_left = 1, gap_left = 0, idle_cycles = 0;
  bit steady = 1'b0;

  // ---------------- fixed-point arithmetic ----------------
  function automatic longint clamp128(logic signed [127:0] v);
    if (v > FX_MAXV) return FX_MAXV;
    if (v < FX_MINV) return FX_MINV;
    return longint'(v[63:0]);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return clamp128(s);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    logic signed [127:0] s;
    s = a;
    s = s - b;
    return clamp128(s);
  endfunction

  // exact product, round half up, arithmetic shift, saturate
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    p = p + (128'sd1 <<< (FRAC_BITS - 1));
    p = p >>> FRAC_BITS;
    return clamp128(p);
  endfunction

  // ---------------- predictor ----------------
  task automatic curve_response(input curve_txn_t t, output curve_resp_t r);
    longint x, u, acc;
    int     found;
    r.val = '0;
    r.st  = ST_OOR;
    r.seg = '0;
    case (t.act)
      ACT_COEF: begin
        if (t.slot < SEGMENTS && t.term <= DEGREE) begin
          coef_mem[t.dir][t.slot][t.term] = t.val;
          r.st = ST_WRITE;
          n_write++;
        end else n_rej++;
      end
      ACT_BREAK: begin
        if (t.slot <= SEGMENTS) begin
          bkpt_mem[t.dir][t.slot] = t.val;
          r.st = ST_WRITE;
          n_write++;
        end else n_rej++;
      end
      ACT_EVAL: begin
        x = t.val;
        r.val = FX_M_ONE;
        found = -1;
        if (!(x < bkpt_mem[t.dir][0] || x >= bkpt_mem[t.dir][SEGMENTS])) begin
          for (int i = 0; i < SEGMENTS; i++)
            if (found < 0 && x < bkpt_mem[t.dir][i+1]) found = i;
        end
        if (found >= 0) begin
          u = fx_mul(scale_regs[t.dir*4+1], fx_sub(x, scale_regs[t.dir*4]));
          acc = coef_mem[t.dir][found][DEGREE];
          for (int k = DEGREE - 1; k >= 0; k--)
            acc = fx_add(fx_mul(acc, u), coef_mem[t.dir][found][k]);
          r.val = fx_add(fx_mul(scale_regs[t.dir*4+2], acc), scale_regs[t.dir*4+3]);
          r.st  = ST_EVAL;
          r.seg = 2'(found);
          n_eval++;
        end else n_oor++;
      end
      default: n_rej++;
    endcase
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        curve_response(cur_txn, new_resp);
        responses_due.push_back(new_resp);
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_txns.size() > 0) begin
        cur_txn = pending_txns.pop_front();
        action <= cur_txn.act;
        direction <= cur_txn.dir;
        slot <= cur_txn.slot;
        term <= cur_txn.term;
        operand_value <= cur_txn.val;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= steady ? 0 : $urandom_range(0, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (!rst && done) begin
      n_done++;
      if (responses_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h status %0d", result_value, status);
      end else begin
        exp_resp = responses_due.pop_front();
        if (result_value !== exp_resp.val || status !== exp_resp.st ||
            segment_used !== exp_resp.seg) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp val %h st %0d seg %0d, got val %h st %0d seg %0d",
                     exp_resp.val, exp_resp.st, exp_resp.seg,
                     result_value, status, segment_used);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("piecewise_quartic_evaluator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic longint rnd_fx();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed({$urandom, $urandom}) >>> $urandom_range(20, 26);
    if (r < 85) return {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return FX_MAXV;
      1: return FX_MINV;
      2: return 0;
      3: return FX_ONE;
      4: return FX_M_ONE;
      5: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic push_txn(logic [1:0] a, logic d, logic [2:0] s, logic [2:0] t,
                          longint v);
    curve_txn_t txn;
    txn = '{a, d, s, t, v};
    if (a == ACT_COEF && s < SEGMENTS && t <= DEGREE) gen_coef_set[d][s][t] = 1'b1;
    if (a == ACT_BREAK && s <= SEGMENTS) begin
      gen_bkpt[d][s] = v;
      gen_bkpt_set[d][s] = 1'b1;
    end
    pending_txns.push_back(txn);
  endtask

  // true when the evaluation reads only written table entries
  function automatic bit eval_is_safe(logic d, longint x);
    if (!gen_bkpt_set[d][0] || !gen_bkpt_set[d][SEGMENTS]) return 0;
    if (x < gen_bkpt[d][0] || x >= gen_bkpt[d][SEGMENTS]) return 1;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (!gen_bkpt_set[d][i+1]) return 0;
      if (x < gen_bkpt[d][i+1]) begin
        for (int k = 0; k <= DEGREE; k++)
          if (!gen_coef_set[d][i][k]) return 0;
        return 1;
      end
    end
    return 1;
  endfunction

  task automatic push_eval(logic d, longint x);
    if (eval_is_safe(d, x))
      push_txn(ACT_EVAL, d, 3'($urandom), 3'($urandom), x);
  endtask

  // fill breakpoints (ascending or scrambled) and all coefficients
  task automatic load_curve(logic d, bit ascending);
    longint b;
    b = $signed({$urandom, $urandom}) >>> 24;
    for (int i = 0; i <= SEGMENTS; i++) begin
      push_txn(ACT_BREAK, d, 3'(i), 3'($urandom), ascending ? b : rnd_fx());
      b = b + (longint'($urandom_range(1, 32'hffff_ffff)) <<< $urandom_range(0, 10));
    end
    for (int s = 0; s < SEGMENTS; s++)
      for (int k = 0; k <= DEGREE; k++)
        push_txn(ACT_COEF, d, 3'(s), 3'(k), rnd_fx());
  endtask

  task automatic pick_eval(logic d);
    longint      lo, hi;
    logic [63:0] span;
    int          r, s;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      s = $urandom_range(0, SEGMENTS - 1);
      lo = gen_bkpt[d][s];
      hi = gen_bkpt[d][s+1];
      span = hi - lo;
      if (hi > lo) push_eval(d, lo + longint'({$urandom, $urandom} % span));
      else push_eval(d, lo);
    end else if (r < 70) push_eval(d, gen_bkpt[d][$urandom_range(0, SEGMENTS)]);
    else if (r < 75) push_eval(d, gen_bkpt[d][0] - 1);
    else push_eval(d, rnd_fx());
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 3))
      0: push_txn(ACT_COEF, 1'($urandom), 3'($urandom_range(SEGMENTS, 7)), 3'($urandom),
                  rnd_fx());
      1: push_txn(ACT_COEF, 1'($urandom), 3'($urandom),
                  3'($urandom_range(DEGREE + 1, 7)), rnd_fx());
      2: push_txn(ACT_BREAK, 1'($urandom), 3'($urandom_range(SEGMENTS + 1, 7)),
                  3'($urandom), rnd_fx());
      default: push_txn(ACT_NONE, 1'($urandom), 3'($urandom), 3'($urandom), rnd_fx());
    endcase
  endtask

  // block until every queued transaction has completed
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_txns.size() != 0 || start || responses_due.size() != 0);
  endtask

  // write all eight offset/gain registers for one setting
  task automatic apply_setting(int mode);
    longint v;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (mode)
        0: v = (i % 4 == 1 || i % 4 == 2) ? FX_ONE : 0;
        1: v = (i % 4 == 1 || i % 4 == 2)
               ? longint'(FX_ONE) + ($signed({$urandom, $urandom}) >>> 26)
               : $signed({$urandom, $urandom}) >>> 24;
        2: v = (i % 2) ? FX_MAXV : FX_MINV;
        3: v = {$urandom, $urandom};
        4: v = (i % 4 == 1 || i % 4 == 2) ? FX_M_ONE : FX_ONE;
        5: v = 0;
        default: v = rnd_fx();
      endcase
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v;
      scale_regs[i] = v;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------- test sequence ----------------
  initial begin
    int r;
    for (int d = 0; d < 2; d++) begin
      for (int s = 0; s <= SEGMENTS; s++) bkpt_mem[d][s] = 0;
      for (int s = 0; s < SEGMENTS; s++)
        for (int k = 0; k <= DEGREE; k++) coef_mem[d][s][k] = 0;
      scale_regs[d*4]   = 0;
      scale_regs[d*4+1] = FX_ONE;
      scale_regs[d*4+2] = FX_ONE;
      scale_regs[d*4+3] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    apply_setting(0);

    // directed: boundaries, bad indexes, unused action
    load_curve(0, 1);
    load_curve(1, 1);
    push_eval(0, gen_bkpt[0][0]);
    push_eval(0, gen_bkpt[0][SEGMENTS]);
    push_eval(0, gen_bkpt[0][0] - 1);
    push_eval(0, gen_bkpt[0][SEGMENTS] - 1);
    push_eval(0, gen_bkpt[0][1]);
    push_eval(0, gen_bkpt[0][2] - 1);
    push_eval(0, gen_bkpt[0][3]);
    push_eval(1, FX_MINV);
    push_eval(1, FX_MAXV);
    push_eval(1, gen_bkpt[1][2]);
    push_txn(ACT_COEF, 0, 3'(SEGMENTS), 3'd0, FX_MAXV);
    push_txn(ACT_COEF, 1, 3'd0, 3'(DEGREE + 1), FX_MINV);
    push_txn(ACT_COEF, 1, 3'd7, 3'd7, -1);
    push_txn(ACT_BREAK, 0, 3'(SEGMENTS + 1), 3'd0, 0);
    push_txn(ACT_BREAK, 1, 3'd7, 3'd7, FX_MAXV);
    push_txn(ACT_BREAK, 0, 3'(SEGMENTS), 3'd7, gen_bkpt[0][SEGMENTS]);
    push_txn(ACT_NONE, 0, 3'd0, 3'd0, 0);
    push_txn(ACT_NONE, 1, 3'd7, 3'd7, -1);
    push_eval(0, gen_bkpt[0][1] - 1);
    wait_drained();

    // random phases, each under a different register setting
    for (int ph = 1; ph <= 6; ph++) begin
      apply_setting(ph);
      steady = (ph == 3);
      if (ph % 2 == 1) begin
        load_curve(0, 1);
        load_curve(1, 1);
      end
      if (ph == 4) load_curve(1, 0);
      for (int n = 0; n < 300; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) pick_eval(1'($urandom));
        else if (r < 85) begin
          if ($urandom_range(0, 1))
            push_txn(ACT_COEF, 1'($urandom), 3'($urandom_range(0, SEGMENTS - 1)),
                     3'($urandom_range(0, DEGREE)), rnd_fx());
          else
            push_txn(ACT_BREAK, 1'($urandom), 3'($urandom_range(0, SEGMENTS)),
                     3'($urandom), rnd_fx());
        end else push_noise();
      end
      // the sender pauses here until every result has arrived
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (responses_due.size() != 0) begin
      n_err++;
      $display("%0d results never arrived", responses_due.size());
    end
    $display("covered %0d results: %0d in-range evals, %0d out of range, %0d writes,",
             n_done, n_eval, n_oor, n_write);
    $display("%0d rejected transactions, seven register settings, both directions",
             n_rej);
    if (n_err == 0) begin
      $display("piecewise_quartic_evaluator test passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("piecewise_quartic_evaluator test failed");
    end
    $finish;
  end

endmodule
